>>> hdl/pma_pkg.sv
package pma_pkg;

	// storage geometry
	localparam int DEPTH          = 1024;
	localparam int WORD_BITS      = 32;
	localparam int BYTE_BITS      = 8;
	localparam int BYTES          = WORD_BITS / BYTE_BITS;
	localparam int ADDR_BITS      = $clog2(DEPTH);
	localparam int POLICY_BITS    = 5;
	localparam int WORDS_BITS     = 11;
	localparam int CFG_DATA_BITS  = 11;
	localparam int CFG_INDEX_BITS = 2;

	// configuration register indexes
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_POLICY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_IDX_WORDS  = 2'd1;

	localparam logic [WORDS_BITS-1:0] WORDS_RESET = 11'd1024;

	// command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// access policy codes
	localparam logic [POLICY_BITS-1:0] POL_RW       = 5'd0;
	localparam logic [POLICY_BITS-1:0] POL_RO       = 5'd1;
	localparam logic [POLICY_BITS-1:0] POL_RC       = 5'd2;
	localparam logic [POLICY_BITS-1:0] POL_RS       = 5'd3;
	localparam logic [POLICY_BITS-1:0] POL_WRC      = 5'd4;
	localparam logic [POLICY_BITS-1:0] POL_WRS      = 5'd5;
	localparam logic [POLICY_BITS-1:0] POL_WC       = 5'd6;
	localparam logic [POLICY_BITS-1:0] POL_WS       = 5'd7;
	localparam logic [POLICY_BITS-1:0] POL_WSRC     = 5'd8;
	localparam logic [POLICY_BITS-1:0] POL_WCRS     = 5'd9;
	localparam logic [POLICY_BITS-1:0] POL_W1C      = 5'd10;
	localparam logic [POLICY_BITS-1:0] POL_W1S      = 5'd11;
	localparam logic [POLICY_BITS-1:0] POL_W1T      = 5'd12;
	localparam logic [POLICY_BITS-1:0] POL_W0C      = 5'd13;
	localparam logic [POLICY_BITS-1:0] POL_W0S      = 5'd14;
	localparam logic [POLICY_BITS-1:0] POL_W0T      = 5'd15;
	localparam logic [POLICY_BITS-1:0] POL_W1SRC    = 5'd16;
	localparam logic [POLICY_BITS-1:0] POL_W1CRS    = 5'd17;
	localparam logic [POLICY_BITS-1:0] POL_W0SRC    = 5'd18;
	localparam logic [POLICY_BITS-1:0] POL_W0CRS    = 5'd19;
	localparam logic [POLICY_BITS-1:0] POL_WO       = 5'd20;
	localparam logic [POLICY_BITS-1:0] POL_WOC      = 5'd21;
	localparam logic [POLICY_BITS-1:0] POL_WOS      = 5'd22;
	localparam logic [POLICY_BITS-1:0] POL_W1       = 5'd23;
	localparam logic [POLICY_BITS-1:0] POL_WO1      = 5'd24;
	localparam logic [POLICY_BITS-1:0] POL_NOACCESS = 5'd25;

	typedef enum logic [1:0] {
		RSP_OK      = 2'd0,
		RSP_REFUSED = 2'd1,
		RSP_RANGE   = 2'd2
	} rsp_status_t;

	typedef struct packed {
		logic                 command;
		logic [ADDR_BITS-1:0] word_index;
		logic [31:0]          write_data;
		logic [3:0]           byte_enable;
	} req_t;

	typedef struct packed {
		rsp_status_t status;
		logic [31:0] read_data;
		logic        changed;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic exec;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;
		logic rsp_stall;
	} ctl_stat_t;

endpackage

>>> hdl/pma_datapath.sv
module pma_datapath import pma_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  req_t                      req,
	input  logic                      rsp_ready,
	output logic                      rsp_valid,
	output rsp_t                      rsp,
	input  ctl_cmd_t                  cmd,
	output ctl_stat_t                 stat
);

	localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);

	logic [POLICY_BITS-1:0] policy_q;
	logic [WORDS_BITS-1:0]  words_q;
	req_t                   req_q;
	logic [ADDR_BITS-1:0]   clr_addr_q;
	logic [WORD_BITS:0]     mem [DEPTH];
	logic [WORD_BITS:0]     rdata_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic                 mem_we;
	logic [ADDR_BITS-1:0] mem_waddr;
	logic [WORD_BITS:0]   mem_wdata;

	logic                 in_range;
	logic [WORD_BITS-1:0] old_word;
	logic                 old_flag;
	logic [WORD_BITS-1:0] new_word;
	logic                 new_flag;
	logic                 upd;
	rsp_status_t          st;
	logic                 once_pol;

	function automatic logic can_read(input logic [POLICY_BITS-1:0] p);
		logic r;
		case (p) inside
			POL_WO, POL_WOC, POL_WOS, POL_WO1, POL_NOACCESS: r = 1'b0;
			default: r = (p <= POL_NOACCESS);
		endcase
		return r;
	endfunction

	function automatic logic can_write(input logic [POLICY_BITS-1:0] p);
		logic r;
		case (p) inside
			POL_RO, POL_RC, POL_RS, POL_NOACCESS: r = 1'b0;
			default: r = (p <= POL_NOACCESS);
		endcase
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] read_effect(input logic [POLICY_BITS-1:0] p,
			input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] r;
		case (p) inside
			POL_RC, POL_WRC, POL_WSRC, POL_W1SRC, POL_W0SRC: r = '0;
			POL_RS, POL_WRS, POL_WCRS, POL_W1CRS, POL_W0CRS: r = '1;
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic logic [WORD_BITS-1:0] write_merge(input logic [POLICY_BITS-1:0] p,
			input logic [WORD_BITS-1:0] o, input logic [WORD_BITS-1:0] v);
		logic [WORD_BITS-1:0] r;
		case (p) inside
			POL_RW, POL_WRC, POL_WRS, POL_WO, POL_W1, POL_WO1: r = v;
			POL_WC, POL_WCRS, POL_WOC: r = '0;
			POL_WS, POL_WSRC, POL_WOS: r = '1;
			POL_W1C, POL_W1CRS: r = o & ~v;
			POL_W1S, POL_W1SRC: r = o | v;
			POL_W1T: r = o ^ v;
			POL_W0C, POL_W0CRS: r = o & v;
			POL_W0S, POL_W0SRC: r = o | ~v;
			POL_W0T: r = o ^ ~v;
			default: r = o;
		endcase
		return r;
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_RW;
			words_q  <= WORDS_RESET;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				CFG_IDX_POLICY: policy_q <= cfg_data[POLICY_BITS-1:0];
				CFG_IDX_WORDS:  words_q  <= cfg_data[WORDS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// request payload capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
	end

	// clearing-pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// word store with written flag in the top bit
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.accept) begin
			rdata_q <= mem[req.word_index];
		end
	end

	assign old_word = rdata_q[WORD_BITS-1:0];
	assign old_flag = rdata_q[WORD_BITS];
	assign in_range = WORDS_BITS'(req_q.word_index) < words_q;
	assign once_pol = (policy_q == POL_W1) || (policy_q == POL_WO1);

	// policy evaluation on the fetched word
	always_comb begin
		new_word = old_word;
		new_flag = old_flag;
		upd      = 1'b0;
		st       = RSP_OK;
		if (!in_range) begin
			st = RSP_RANGE;
		end else if (req_q.command == CMD_READ) begin
			if (!can_read(policy_q)) begin
				st = RSP_REFUSED;
			end else begin
				new_word = read_effect(policy_q, old_word);
				upd      = 1'b1;
			end
		end else if (!can_write(policy_q)) begin
			st = RSP_REFUSED;
		end else if (req_q.byte_enable != '0) begin
			if (!(once_pol && old_flag)) begin
				new_word = write_merge(policy_q, old_word, req_q.write_data);
			end
			// disabled bytes keep their old value
			for (int b = 0; b < BYTES; b++) begin
				if (!req_q.byte_enable[b]) begin
					new_word[b*BYTE_BITS +: BYTE_BITS] = old_word[b*BYTE_BITS +: BYTE_BITS];
				end
			end
			new_flag = old_flag | once_pol;
			upd      = 1'b1;
		end
	end

	// memory write port: clearing pass or write-back
	always_comb begin
		if (cmd.clear) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = cmd.exec & upd;
			mem_waddr = req_q.word_index;
			mem_wdata = {new_flag, new_word};
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.status <= st;
			if (st == RSP_OK) begin
				rsp_q.read_data <= (req_q.command == CMD_READ) ? old_word : new_word;
				rsp_q.changed   <= new_word != old_word;
			end else begin
				rsp_q.read_data <= '0;
				rsp_q.changed   <= 1'b0;
			end
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign rsp             = rsp_q;
	assign stat.clear_done = (clr_addr_q == LAST_ADDR);
	assign stat.rsp_stall  = rsp_valid_q & ~rsp_ready;

endmodule

>>> hdl/pma_ctrl.sv
module pma_ctrl import pma_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  ctl_stat_t stat,
	output ctl_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_EXEC  = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (stat.clear_done) state_d = S_IDLE;
			S_IDLE:  if (req_valid) state_d = S_EXEC;
			S_EXEC:  if (!stat.rsp_stall) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// commands
	assign req_ready  = (state_q == S_IDLE);
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.accept = req_ready & req_valid;
	assign cmd.exec   = (state_q == S_EXEC) & ~stat.rsp_stall;

endmodule

>>> hdl/policy_memory_access_core.sv
// A request beat accepted at a clock edge reads the word store into a register
// at that edge; then, in S_EXEC, the policy merge and write-back complete and
// the response beat is registered. A new request is taken only in S_IDLE, once
// the last one is through; a held response beat stalls the next.
// Reset: asynchronous; afterwards a clearing pass zeroes the 1024 words and
// written flags with req_ready low. Config writes are taken.
module policy_memory_access_core import pma_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write_en,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  req_t                      req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output rsp_t                      rsp
);

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	pma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pma_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req          (req),
		.rsp_ready    (rsp_ready),
		.rsp_valid    (rsp_valid),
		.rsp          (rsp),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
